@@ design/vdsg_pkg.sv @@
// Shared types, constants, stroke tables and helper functions for the digit stroke generator.
`default_nettype none
package vdsg_pkg;

    localparam int VALUE_W     = 31;
    localparam int COORD_W     = 16;
    localparam int WIDE_W      = 18;
    localparam int BCD_DIGITS  = 10;
    localparam int BCD_W       = 4 * BCD_DIGITS;
    localparam int BIT_CNT_W   = $clog2(VALUE_W);
    localparam int POLY_MAX    = 7;
    localparam int PT_W        = $clog2(POLY_MAX);
    localparam int CFG_W       = 8;
    localparam int CFG_IDX_W   = 1;
    localparam int IN_DATA_W   = 64;
    localparam int OUT_DATA_W  = 64;

    localparam int MAX_DIGITS_DEF = 10;

    localparam logic [CFG_W-1:0] SCALE_RESET = 8'd20;
    localparam logic [CFG_W-1:0] GAP_RESET   = 8'd10;

    localparam logic [CFG_IDX_W-1:0] REG_CELL_SCALE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_DIGIT_GAP  = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic load;
        logic conv_step;
        logic seg_load;
        logic seg_adv;
        logic digit_adv;
    } cmd_t;

    typedef struct packed {
        logic conv_last;
        logic seg_last;
        logic digit_last;
    } stat_t;

    // Number of polyline points per digit.
    localparam logic [2:0] POLY_LEN [BCD_DIGITS] = '{
        3'd5, 3'd2, 3'd6, 3'd7, 3'd5, 3'd6, 3'd6, 3'd3, 3'd7, 3'd5
    };

    localparam logic [1:0] POLY_X [BCD_DIGITS][POLY_MAX] = '{
        '{2'd0, 2'd1, 2'd1, 2'd0, 2'd0, 2'd0, 2'd0},
        '{2'd1, 2'd1, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0},
        '{2'd0, 2'd1, 2'd1, 2'd0, 2'd0, 2'd1, 2'd0},
        '{2'd0, 2'd1, 2'd1, 2'd0, 2'd1, 2'd1, 2'd0},
        '{2'd0, 2'd0, 2'd1, 2'd1, 2'd1, 2'd0, 2'd0},
        '{2'd1, 2'd0, 2'd0, 2'd1, 2'd1, 2'd0, 2'd0},
        '{2'd1, 2'd0, 2'd0, 2'd1, 2'd1, 2'd0, 2'd0},
        '{2'd0, 2'd1, 2'd1, 2'd0, 2'd0, 2'd0, 2'd0},
        '{2'd0, 2'd0, 2'd1, 2'd1, 2'd0, 2'd0, 2'd1},
        '{2'd1, 2'd0, 2'd0, 2'd1, 2'd1, 2'd0, 2'd0}
    };

    localparam logic [1:0] POLY_Y [BCD_DIGITS][POLY_MAX] = '{
        '{2'd0, 2'd0, 2'd2, 2'd2, 2'd0, 2'd0, 2'd0},
        '{2'd0, 2'd2, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0},
        '{2'd0, 2'd0, 2'd1, 2'd1, 2'd2, 2'd2, 2'd0},
        '{2'd0, 2'd0, 2'd1, 2'd1, 2'd1, 2'd2, 2'd2},
        '{2'd0, 2'd1, 2'd1, 2'd0, 2'd2, 2'd0, 2'd0},
        '{2'd0, 2'd0, 2'd1, 2'd1, 2'd2, 2'd2, 2'd0},
        '{2'd0, 2'd0, 2'd2, 2'd2, 2'd1, 2'd1, 2'd0},
        '{2'd0, 2'd0, 2'd2, 2'd0, 2'd0, 2'd0, 2'd0},
        '{2'd1, 2'd0, 2'd0, 2'd2, 2'd2, 2'd1, 2'd1},
        '{2'd1, 2'd1, 2'd0, 2'd0, 2'd2, 2'd0, 2'd0}
    };

    // Grid coordinate times scale; grid values are 0, 1 or 2.
    function automatic logic [CFG_W+1:0] grid_offset(input logic [1:0] p,
                                                     input logic [CFG_W-1:0] sc);
        logic [CFG_W+1:0] r;
        case (p)
            2'd0:    r = '0;
            2'd1:    r = {2'b00, sc};
            default: r = {1'b0, sc, 1'b0};
        endcase
        return r;
    endfunction

    // Clamp a wide signed coordinate to the 16-bit signed range.
    function automatic logic [COORD_W-1:0] sat16(input logic signed [WIDE_W-1:0] v);
        logic [COORD_W-1:0] r;
        if ((v[WIDE_W-1:COORD_W-1] == '0) || (v[WIDE_W-1:COORD_W-1] == '1)) begin
            r = v[COORD_W-1:0];
        end else if (v[WIDE_W-1]) begin
            r = 16'h8000;
        end else begin
            r = 16'h7FFF;
        end
        return r;
    endfunction

endpackage
`default_nettype wire

@@ design/vdsg_ctrl.sv @@
// Controller state machine: sequences conversion and segment emission, owns the output valid.
`default_nettype none
module vdsg_ctrl (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           s_tvalid,
    output logic                s_tready,
    output logic                m_tvalid,
    input  wire logic           m_tready,
    input  wire vdsg_pkg::stat_t stat,
    output vdsg_pkg::cmd_t      cmd
);

    vdsg_pkg::state_t state_reg, state_next;
    logic out_valid_reg, out_valid_next;
    logic out_free;

    assign out_free = !out_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= vdsg_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            vdsg_pkg::ST_IDLE: begin
                if (s_tvalid) state_next = vdsg_pkg::ST_CONV;
            end
            vdsg_pkg::ST_CONV: begin
                if (stat.conv_last) state_next = vdsg_pkg::ST_EMIT;
            end
            vdsg_pkg::ST_EMIT: begin
                if (out_free && stat.seg_last && stat.digit_last) begin
                    state_next = vdsg_pkg::ST_IDLE;
                end
            end
            default: state_next = vdsg_pkg::ST_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        cmd      = '0;
        s_tready = 1'b0;
        case (state_reg)
            vdsg_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                cmd.load = s_tvalid;
            end
            vdsg_pkg::ST_CONV: begin
                cmd.conv_step = 1'b1;
            end
            vdsg_pkg::ST_EMIT: begin
                cmd.seg_load  = out_free;
                cmd.seg_adv   = out_free && !stat.seg_last;
                cmd.digit_adv = out_free && stat.seg_last && !stat.digit_last;
            end
            default: ;
        endcase
    end

    always_comb begin
        if (cmd.seg_load) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    assign m_tvalid = out_valid_reg;

`ifndef ASSERT_OFF
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.seg_load |-> (!out_valid_reg || m_tready))
        else $error("segment loaded over an untaken word");

    a_accept_to_conv: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> (state_reg == vdsg_pkg::ST_CONV))
        else $error("accepted word did not start conversion");

    a_conv_to_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == vdsg_pkg::ST_CONV && stat.conv_last)
            |=> (state_reg == vdsg_pkg::ST_EMIT))
        else $error("conversion end did not start emission");

    a_one_step_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({cmd.load, cmd.conv_step, cmd.seg_load}))
        else $error("conflicting datapath commands");
`endif

endmodule
`default_nettype wire

@@ design/vdsg_datapath.sv @@
// Datapath: config registers, binary to BCD conversion, digit walk and segment output register.
`default_nettype none
module vdsg_datapath #(
    parameter int MAX_DIGITS = vdsg_pkg::MAX_DIGITS_DEF
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              cfg_we,
    input  wire logic [vdsg_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [vdsg_pkg::CFG_W-1:0]        cfg_data,
    input  wire logic [vdsg_pkg::IN_DATA_W-1:0]    s_tdata,
    input  wire vdsg_pkg::cmd_t                    cmd,
    output vdsg_pkg::stat_t                        stat,
    output logic [vdsg_pkg::OUT_DATA_W-1:0]        m_tdata,
    output logic                                   m_tlast
);

    localparam int DIG_CNT_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
    localparam int VW = vdsg_pkg::VALUE_W;
    localparam int CW = vdsg_pkg::COORD_W;
    localparam int WW = vdsg_pkg::WIDE_W;

    logic [vdsg_pkg::CFG_W-1:0]      scale_reg, gap_reg;
    logic [VW-1:0]                   bin_reg;
    logic [vdsg_pkg::BCD_W-1:0]      bcd_reg, bcd_adj;
    logic [vdsg_pkg::BIT_CNT_W-1:0]  bit_cnt_reg;
    logic [vdsg_pkg::PT_W-1:0]       pt_reg, pt_nxt;
    logic [DIG_CNT_W-1:0]            dig_cnt_reg;
    logic signed [WW-1:0]            left_reg, top_reg;
    logic [vdsg_pkg::OUT_DATA_W-1:0] data_reg;
    logic                            last_reg;

    logic [3:0]               digit;
    logic [2:0]               plen;
    logic [vdsg_pkg::CFG_W:0] pitch;
    logic signed [WW-1:0]     x0, y0, x1, y1;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scale_reg <= vdsg_pkg::SCALE_RESET;
            gap_reg   <= vdsg_pkg::GAP_RESET;
        end else if (cfg_we) begin
            case (cfg_index)
                vdsg_pkg::REG_CELL_SCALE: scale_reg <= cfg_data;
                vdsg_pkg::REG_DIGIT_GAP:  gap_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    // Add three to every nibble of five or more before the shift
    always_comb begin
        logic [3:0] nib;
        for (int i = 0; i < vdsg_pkg::BCD_DIGITS; i++) begin
            nib = bcd_reg[4*i +: 4];
            bcd_adj[4*i +: 4] = (nib >= 4'd5) ? (nib + 4'd3) : nib;
        end
    end

    assign digit  = bcd_reg[3:0];
    assign plen   = vdsg_pkg::POLY_LEN[digit];
    assign pt_nxt = pt_reg + 3'd1;
    assign pitch  = {1'b0, scale_reg} + {1'b0, gap_reg};

    assign x0 = left_reg + WW'(vdsg_pkg::grid_offset(vdsg_pkg::POLY_X[digit][pt_reg], scale_reg));
    assign y0 = top_reg  + WW'(vdsg_pkg::grid_offset(vdsg_pkg::POLY_Y[digit][pt_reg], scale_reg));
    assign x1 = left_reg + WW'(vdsg_pkg::grid_offset(vdsg_pkg::POLY_X[digit][pt_nxt], scale_reg));
    assign y1 = top_reg  + WW'(vdsg_pkg::grid_offset(vdsg_pkg::POLY_Y[digit][pt_nxt], scale_reg));

    assign stat.conv_last  = (bit_cnt_reg == vdsg_pkg::BIT_CNT_W'(VW - 1));
    assign stat.seg_last   = ((pt_reg + 3'd2) == plen);
    assign stat.digit_last = (bcd_reg[vdsg_pkg::BCD_W-1:4] == '0)
                          || (dig_cnt_reg == DIG_CNT_W'(MAX_DIGITS - 1));

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            bin_reg     <= s_tdata[VW-1:0];
            bcd_reg     <= '0;
            bit_cnt_reg <= '0;
            pt_reg      <= '0;
            dig_cnt_reg <= '0;
            left_reg    <= WW'(signed'(s_tdata[VW +: CW]));
            top_reg     <= WW'(signed'(s_tdata[VW+CW +: CW]));
        end else if (cmd.conv_step) begin
            bcd_reg     <= {bcd_adj[vdsg_pkg::BCD_W-2:0], bin_reg[VW-1]};
            bin_reg     <= {bin_reg[VW-2:0], 1'b0};
            bit_cnt_reg <= bit_cnt_reg + 1'b1;
        end else if (cmd.seg_adv) begin
            pt_reg <= pt_nxt;
        end else if (cmd.digit_adv) begin
            // drop the finished digit and step one cell to the left
            bcd_reg     <= {4'd0, bcd_reg[vdsg_pkg::BCD_W-1:4]};
            pt_reg      <= '0;
            dig_cnt_reg <= dig_cnt_reg + 1'b1;
            left_reg    <= left_reg - WW'(pitch);
        end
    end

    // Output payload register
    always_ff @(posedge aclk) begin
        if (cmd.seg_load) begin
            data_reg <= {vdsg_pkg::sat16(y1), vdsg_pkg::sat16(x1),
                         vdsg_pkg::sat16(y0), vdsg_pkg::sat16(x0)};
            last_reg <= stat.seg_last && stat.digit_last;
        end
    end

    assign m_tdata = data_reg;
    assign m_tlast = last_reg;

endmodule
`default_nettype wire

@@ design/vector_digit_stroke_generator.sv @@
// Top level of the vector digit stroke generator: stream ports, controller and datapath.
`default_nettype none
// Draws a non-negative 31-bit number as line segments. One input word carries the value
// and the origin of the least significant digit cell; the block splits the value into
// decimal digits, least significant first, and walks each digit's fixed polyline on a
// 1-by-2 grid, sending one segment word per pair of consecutive points. Grid units are
// multiplied by cell_scale (register 0, reset 20), and digit i sits at
// origin_x - i * (cell_scale + digit_gap), digit_gap being register 1 (reset 10). All
// cells share origin_y as top edge. Zero draws as the single digit 0; only the
// MAX_DIGITS low digits are drawn. Each coordinate is saturated to 16-bit signed, and
// m_tlast marks the final segment of a value (1 to 6*MAX_DIGITS segments per value).
// Sequencing: after acceptance the value goes through a bit-serial binary-to-BCD
// converter, one bit a cycle; then one segment is produced per cycle while m_tready
// is high. The next word is taken as soon as the last segment has entered the output
// register.
// Write configuration only while the block is idle.
module vector_digit_stroke_generator #(
    parameter int MAX_DIGITS = vdsg_pkg::MAX_DIGITS_DEF
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    // configuration write port
    input  wire logic                              cfg_we,
    input  wire logic [vdsg_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [vdsg_pkg::CFG_W-1:0]        cfg_data,
    // input words
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // value[30:0], origin_x[46:31], origin_y[62:47], zero pad [63]
    input  wire logic [vdsg_pkg::IN_DATA_W-1:0]    s_tdata,
    // segment words
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // seg_x0[15:0], seg_y0[31:16], seg_x1[47:32], seg_y1[63:48]
    output logic [vdsg_pkg::OUT_DATA_W-1:0]        m_tdata,
    // last_segment
    output logic                                   m_tlast
);

    vdsg_pkg::cmd_t  cmd;
    vdsg_pkg::stat_t stat;

    // Sequence accept, conversion and emission; hold the output valid
    vdsg_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Convert, walk the stroke tables and build segment words
    vdsg_datapath #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tdata   (s_tdata),
        .cmd       (cmd),
        .stat      (stat),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

endmodule
`default_nettype wire

@@ tb/tb_vector_digit_stroke_generator.sv @@
// Self-checking testbench for the vector digit stroke generator.
`default_nettype none
module tb_vector_digit_stroke_generator;

    localparam int QUIET_LIMIT  = 2000;  // cycles with no word moving before giving up
    localparam int HOLD_CYCLES  = 400;   // long receiver hold-off
    localparam int SETTLE       = 40;    // margin for the conversion that follows acceptance
    localparam int DIGIT_LIMIT  = vdsg_pkg::MAX_DIGITS_DEF;

    typedef struct packed {
        logic signed [15:0] x0;
        logic signed [15:0] y0;
        logic signed [15:0] x1;
        logic signed [15:0] y1;
        logic               last;
    } stroke_t;

    typedef struct packed {
        logic [30:0]        value;
        logic signed [15:0] ox;
        logic signed [15:0] oy;
        logic               typed;   // expected stroke given below, single-segment value
        stroke_t            want;
    } dir_row_t;

    logic aclk;
    logic aresetn;
    logic cfg_we;
    logic [vdsg_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [vdsg_pkg::CFG_W-1:0] cfg_data;
    logic s_tvalid;
    logic s_tready;
    logic [vdsg_pkg::IN_DATA_W-1:0] s_tdata;    // value[30:0], origin_x[46:31], origin_y[62:47]
    logic m_tvalid;
    logic m_tready;
    logic [vdsg_pkg::OUT_DATA_W-1:0] m_tdata;   // seg_x0, seg_y0, seg_x1, seg_y1 from bit 0
    logic m_tlast;

    vector_digit_stroke_generator dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    // Shadow copy of the two registers.
    logic [7:0] scale_reg;
    logic [7:0] gap_reg;

    stroke_t pending_strokes[$];
    int      stroke_errors;
    int      send_idle_pct;
    int      recv_stall_pct;
    bit      hold_request;
    int      quiet_cycles;
    stroke_t got_stroke;
    stroke_t want_stroke;
    dir_row_t directed_rows [20];

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // Append one stroke to the tail of the expected queue.
    function automatic void add_stroke(input stroke_t s);
        pending_strokes = {pending_strokes, s};
    endfunction

    // Polyline of each digit on the 1-by-2 grid, points as "xy" pairs.
    function automatic string glyph_path(input int dig);
        case (dig)
            0: return "00 10 12 02 00";
            1: return "10 12";
            2: return "00 10 11 01 02 12";
            3: return "00 10 11 01 11 12 02";
            4: return "00 01 11 10 12";
            5: return "10 00 01 11 12 02";
            6: return "10 00 02 12 11 01";
            7: return "00 10 12";
            8: return "01 00 10 12 02 01 11";
            default: return "11 01 00 10 12";
        endcase
    endfunction

    function automatic logic signed [15:0] clamp16(input int v);
        if (v > 32767) return 16'sh7FFF;
        if (v < -32768) return 16'sh8000;
        return v[15:0];
    endfunction

    // Queue up every stroke of one number under the current register settings.
    function automatic void draw_number(input logic [30:0] value, input logic signed [15:0] ox,
                                        input logic signed [15:0] oy);
        int unsigned v;
        int pitch, sc, left, d, dig, j, n;
        int px0, py0, px1, py1;
        string path;
        stroke_t seg;
        bit have;
        v = value;
        sc = int'(scale_reg);
        pitch = int'(scale_reg) + int'(gap_reg);
        d = 0;
        have = 1'b0;
        seg = '0;
        do begin
            dig = v % 10;
            v = v / 10;
            left = int'(ox) - pitch * d;
            path = glyph_path(dig);
            n = (path.len() + 1) / 3;
            for (j = 0; j + 1 < n; j++) begin
                if (have) add_stroke(seg);
                px0 = path[3*j] - "0";
                py0 = path[3*j+1] - "0";
                px1 = path[3*j+3] - "0";
                py1 = path[3*j+4] - "0";
                seg.x0 = clamp16(left + px0 * sc);
                seg.y0 = clamp16(int'(oy) + py0 * sc);
                seg.x1 = clamp16(left + px1 * sc);
                seg.y1 = clamp16(int'(oy) + py1 * sc);
                seg.last = 1'b0;
                have = 1'b1;
            end
            d++;
        end while (v != 0 && d < DIGIT_LIMIT);
        // flag the final stroke of the number
        seg.last = 1'b1;
        add_stroke(seg);
    endfunction

    // Offer one word, with random idle cycles ahead of it, and predict at acceptance.
    task automatic push_word(input logic [30:0] value, input logic signed [15:0] ox,
                             input logic signed [15:0] oy, input bit typed, input stroke_t want);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid = 1'b0;
            s_tdata = {$urandom, $urandom};
            @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata = {1'b0, oy, ox, value};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        if (typed) add_stroke(want);
        else draw_number(value, ox, oy);
        @(negedge aclk);
    endtask

    // Hold the input side until every queued stroke is out, then let the block settle.
    task automatic wait_drained();
        s_tvalid = 1'b0;
        while (pending_strokes.size() != 0) @(negedge aclk);
        repeat (SETTLE) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [vdsg_pkg::CFG_IDX_W-1:0] idx, input logic [7:0] data);
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_data = data;
        if (idx == vdsg_pkg::REG_CELL_SCALE) scale_reg = data;
        else gap_reg = data;
        @(negedge aclk);
        cfg_we = 1'b0;
        cfg_data = 8'($urandom);
    endtask

    task automatic set_regs(input logic [7:0] sc, input logic [7:0] gp);
        wait_drained();
        write_reg(vdsg_pkg::REG_CELL_SCALE, sc);
        write_reg(vdsg_pkg::REG_DIGIT_GAP, gp);
    endtask

    function automatic logic [30:0] pick_value();
        int k;
        case ($urandom_range(3))
            0: return 31'($urandom_range(99));
            1: return 31'($urandom);
            2: begin
                k = $urandom_range(1, 9);
                return 31'($urandom_range(10 ** k - 1, 10 ** (k - 1)));
            end
            default: return 31'($urandom_range(32'h7FFF_FFFF, 1_000_000_000));
        endcase
    endfunction

    // Half full-range origins, the rest close to either edge to hit saturation.
    function automatic logic signed [15:0] pick_coord();
        case ($urandom_range(3))
            0: return 16'sh8000 + 16'($urandom_range(600));
            1: return 16'sh7FFF - 16'($urandom_range(600));
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic send_random(input int count);
        repeat (count) push_word(pick_value(), pick_coord(), pick_coord(), 1'b0, '0);
    endtask

    // Receiver: random stalls, plus a long hold-off on request.
    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_request) begin
                m_tready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
                hold_request = 1'b0;
            end else begin
                m_tready = ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // Check each segment word against the oldest expected stroke.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            got_stroke = {m_tdata[15:0], m_tdata[31:16], m_tdata[47:32], m_tdata[63:48],
                          m_tlast};
            if (pending_strokes.size() == 0) begin
                stroke_errors++;
                if (stroke_errors <= 10)
                    $display("unexpected stroke (%0d,%0d)-(%0d,%0d) last=%0b", got_stroke.x0,
                             got_stroke.y0, got_stroke.x1, got_stroke.y1, got_stroke.last);
            end else begin
                want_stroke = pending_strokes.pop_front();
                if (got_stroke.x0 !== want_stroke.x0 || got_stroke.y0 !== want_stroke.y0 ||
                    got_stroke.x1 !== want_stroke.x1 || got_stroke.y1 !== want_stroke.y1 ||
                    got_stroke.last !== want_stroke.last) begin
                    stroke_errors++;
                    if (stroke_errors <= 10)
                        $display(
                            "want (%0d,%0d)-(%0d,%0d) %0b got (%0d,%0d)-(%0d,%0d) %0b",
                            want_stroke.x0, want_stroke.y0, want_stroke.x1,
                            want_stroke.y1, want_stroke.last, got_stroke.x0,
                            got_stroke.y0, got_stroke.x1, got_stroke.y1,
                            got_stroke.last);
                end
            end
        end
    end

    // Count cycles in which no word moves and nothing is configured.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial begin
        wait (quiet_cycles >= QUIET_LIMIT);
        $display("tb_vector_digit_stroke_generator: FAIL");
        $finish;
    end

    initial begin
        aresetn = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        stroke_errors = 0;
        quiet_cycles = 0;
        hold_request = 1'b0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        scale_reg = 8'd20;
        gap_reg = 8'd10;

        // Digit one is a single vertical stroke, so its whole result is typed in.
        directed_rows = '{
            '{31'd1,          16'sd0,      16'sd0,      1'b1,
              '{16'sd20, 16'sd0, 16'sd20, 16'sd40, 1'b1}},
            '{31'd1,          16'sh8000,   16'sh8000,   1'b1,
              '{-16'sd32748, 16'sh8000, -16'sd32748, -16'sd32728, 1'b1}},
            '{31'd1,          16'sh7FFF,   16'sh7FFF,   1'b1,
              '{16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 1'b1}},
            '{31'd0,          16'sd100,    16'sd50,     1'b0, '0},
            '{31'd2,          16'sd100,    16'sd50,     1'b0, '0},
            '{31'd3,          -16'sd100,   16'sd50,     1'b0, '0},
            '{31'd4,          16'sd100,    -16'sd50,    1'b0, '0},
            '{31'd5,          16'sd0,      16'sd0,      1'b0, '0},
            '{31'd6,          16'sd0,      16'sd0,      1'b0, '0},
            '{31'd7,          16'sh7FFF,   16'sh7FFF,   1'b0, '0},
            '{31'd8,          16'sd0,      16'sd0,      1'b0, '0},
            '{31'd9,          16'sd0,      16'sd0,      1'b0, '0},
            '{31'd10,         16'sd300,    16'sd300,    1'b0, '0},
            '{31'd1234567890, 16'sd1000,   16'sd200,    1'b0, '0},
            '{31'h7FFF_FFFF,  16'sd0,      16'sd0,      1'b0, '0},
            '{31'h7FFF_FFFF,  -16'sd32500, 16'sd32700,  1'b0, '0},
            '{31'd1000000000, 16'sd32767,  -16'sd32768, 1'b0, '0},
            '{31'd999999999,  16'sd4000,   16'sd0,      1'b0, '0},
            '{31'd90817,      16'sh8000,   16'sd32747,  1'b0, '0},
            '{31'd1357924680, 16'sh7FFF,   16'sh8000,   1'b0, '0}
        };

        repeat (6) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        // Directed part at reset settings, no idling.
        foreach (directed_rows[i])
            push_word(directed_rows[i].value, directed_rows[i].ox, directed_rows[i].oy,
                      directed_rows[i].typed, directed_rows[i].want);

        // Largest scale and gap, no idling.
        set_regs(8'd255, 8'd255);
        send_random(45);

        // Smallest nonzero scale, no gap; sender idles often.
        set_regs(8'd1, 8'd0);
        send_idle_pct = 63;
        send_random(45);

        // Zero scale collapses strokes; receiver stalls often, then holds off for long.
        set_regs(8'd0, 8'($urandom));
        send_idle_pct = 0;
        recv_stall_pct = 63;
        send_random(15);
        hold_request = 1'b1;
        send_random(15);
        wait_drained();
        send_random(15);

        // Random settings, both sides idling.
        set_regs(8'($urandom_range(255, 1)), 8'($urandom));
        send_idle_pct = 29;
        recv_stall_pct = 29;
        send_random(45);

        // Back to full speed with another random setting.
        set_regs(8'($urandom_range(255, 1)), 8'($urandom));
        send_idle_pct = 0;
        recv_stall_pct = 0;
        send_random(20);

        wait_drained();
        repeat (60) @(negedge aclk);
        if (stroke_errors == 0 && pending_strokes.size() == 0)
            $display("tb_vector_digit_stroke_generator: PASS");
        else
            $display("tb_vector_digit_stroke_generator: FAIL");
        $finish;
    end

endmodule
`default_nettype wire

@@ vector_digit_stroke_generator.f @@
design/vdsg_pkg.sv
design/vdsg_ctrl.sv
design/vdsg_datapath.sv
design/vector_digit_stroke_generator.sv
tb/tb_vector_digit_stroke_generator.sv
